FILE: design/error_diffusion_dither_assert.svh
// Assertion macros used by the top-level dither design file.
`ifndef ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define ERROR_DIFFUSION_DITHER_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define EDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define EDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/edd_pkg.sv
// Package with widths, constants and register codes of the error diffusion dither.
`timescale 1ns / 1ps

package edd_pkg;

  localparam int GRAY_W        = 8;
  localparam int ERR_W         = 3;
  localparam int WIDTH_W       = 10;
  localparam int HEIGHT_W      = 13;
  localparam int ROW_W         = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 13;
  localparam int MAX_HEIGHT    = 4096;
  localparam int DEF_MAX_WIDTH = 512;

  localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = WIDTH_W'(256);
  localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT = HEIGHT_W'(256);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

FILE: design/edd_ifs.sv
// Handshake interfaces for pixel input, result output and configuration writes.
`timescale 1ns / 1ps

interface edd_pixel_if import edd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_in;

  modport source (output valid, output gray_in, input ready);
  modport sink (input valid, input gray_in, output ready);
endinterface

interface edd_result_if import edd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] level_out;
  logic              frame_end;

  modport source (output valid, output level_out, output frame_end, input ready);
  modport sink (input valid, input level_out, input frame_end, output ready);
endinterface

interface edd_cfg_if import edd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/error_diffusion_dither.sv
// Top level of the error diffusion dither: line store, diffusion stage and output register.
`timescale 1ns / 1ps
`include "error_diffusion_dither_assert.svh"

// Error diffusion dither, 16 output levels.
// Channels: pixels (sink) takes 8-bit gray pixels of one frame in raster order;
// results (source) returns one quantized level per pixel, with frame_end set on
// the last pixel of the frame; cfg (sink, always ready) writes image_width
// (index 0) and image_height (index 1). The user must write them only while no
// pixel is in flight; the block does not enforce it. Throughput: one pixel per
// clock while results is ready. The line store of next-row error is read when a
// request is accepted and written back one column behind, so the carry to the
// right neighbor sets the rate. A result passes the diffusion stage register and
// then waits in the output register until results takes it.
// Reset: counters, carries and registers return to their defaults (width and
// height 256) at once; the line store is not cleared, since the first row of
// every frame ignores it.
// Stall: while results is not ready the output register holds, the diffusion
// stage holds one more pixel, and then pixels drops ready.

module error_diffusion_dither import edd_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic  clk,
  input  logic  rst,
  edd_pixel_if.sink    pixels,
  edd_result_if.source results,
  edd_cfg_if.sink      cfg
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [CW-1:0]     col;
    logic              first_row;
    logic              last_col;
    logic              last_row;
  } stage_t;

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic [CW-1:0]       col_count;
  logic [ROW_W-1:0]    row_count;
  logic [XW-1:0]       w_last;
  logic [HEIGHT_W-1:0] h_last;
  logic                last_col;
  logic                last_row;
  logic                accept;

  stage_t              s1;
  logic                s1_valid;
  logic                s1_adv;
  logic [ERR_W-1:0]    right_carry;
  logic [ERR_W-1:0]    pend_below;
  logic                fwd_hit;
  logic [ERR_W-1:0]    fwd_data;
  logic                dfr_valid;
  logic [CW-1:0]       dfr_addr;
  logic [ERR_W-1:0]    dfr_data;

  logic [ERR_W-1:0]    ram_q;
  logic                wr_en;
  logic [CW-1:0]       wr_addr;
  logic [ERR_W-1:0]    wr_data;

  logic [ERR_W-1:0]    above;
  logic [GRAY_W:0]     sum_raw;
  logic [GRAY_W-1:0]   sum_sat;
  logic [3:0]          err;
  logic [5:0]          prod3;
  logic [6:0]          prod5;
  logic [6:0]          prod7;
  logic [ERR_W-1:0]    b3;
  logic [ERR_W-1:0]    b5;
  logic [ERR_W-1:0]    b7;

  logic                out_valid;
  logic [GRAY_W-1:0]   out_level;
  logic                out_end;

  // Configuration registers; the port never stalls.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data[WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Last column and last row of the effective frame size.
  always_comb begin
    if (image_width == '0) begin
      w_last = '0;
    end else if (XW'(image_width) > XW'(MAX_WIDTH)) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(image_width) - XW'(1);
    end
    if (image_height == '0) begin
      h_last = '0;
    end else if (image_height > HEIGHT_W'(MAX_HEIGHT)) begin
      h_last = HEIGHT_W'(MAX_HEIGHT - 1);
    end else begin
      h_last = image_height - HEIGHT_W'(1);
    end
  end

  assign last_col = XW'(col_count) >= w_last;
  assign last_row = {1'b0, row_count} >= h_last;

  // Handshake: the diffusion stage moves on when the output register frees up.
  assign s1_adv       = s1_valid && (!out_valid || results.ready);
  assign pixels.ready = !s1_valid || s1_adv;
  assign accept       = pixels.valid && pixels.ready;

  // Raster position advances when a request is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_count <= '0;
        row_count <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // Line store of error for the next row.
  edd_ram #(
    .WIDTH (ERR_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (accept),
    .raddr (col_count),
    .rdata (ram_q)
  );

  // Diffusion stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.gray      <= pixels.gray_in;
      s1.col       <= col_count;
      s1.first_row <= (row_count == '0);
      s1.last_col  <= last_col;
      s1.last_row  <= last_row;
    end
  end

  // Forwarding of writes to the entry being read that the RAM does not return.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit  <= wr_en && (wr_addr == col_count);
      fwd_data <= wr_data;
    end else if (s1_valid && dfr_valid && (dfr_addr == s1.col)) begin
      fwd_hit  <= 1'b1;
      fwd_data <= dfr_data;
    end
  end

  // Error from above: zero on the first row, newest write first.
  always_comb begin
    if (s1.first_row) begin
      above = '0;
    end else if (dfr_valid && (dfr_addr == s1.col)) begin
      above = dfr_data;
    end else if (fwd_hit) begin
      above = fwd_data;
    end else begin
      above = ram_q;
    end
  end

  // Saturating sum, quantization and truncated error shares.
  always_comb begin
    sum_raw = {1'b0, s1.gray} + (GRAY_W + 1)'(right_carry) + (GRAY_W + 1)'(above);
    sum_sat = sum_raw[GRAY_W] ? '1 : sum_raw[GRAY_W-1:0];
    err     = sum_sat[3:0];
    prod3   = {2'b00, err} + {1'b0, err, 1'b0};
    prod5   = {3'b000, err} + {1'b0, err, 2'b00};
    prod7   = {err, 3'b000} - {3'b000, err};
    b3      = {1'b0, prod3[5:4]};
    b5      = prod5[6:4];
    b7      = prod7[6:4];
  end

  // Row carries for the pixel to the right and the below share still open.
  always_ff @(posedge clk) begin
    if (rst) begin
      right_carry <= '0;
      pend_below  <= '0;
    end else if (s1_adv) begin
      if (s1.last_col) begin
        right_carry <= '0;
        pend_below  <= '0;
      end else begin
        right_carry <= b7;
        pend_below  <= b5;
      end
    end
  end

  // The last column's own below share is written in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      dfr_valid <= 1'b0;
    end else begin
      dfr_valid <= s1_adv && s1.last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      dfr_addr <= s1.col;
      dfr_data <= b5;
    end
  end

  // Line store write port: deferred write, else the previous column's entry.
  always_comb begin
    if (dfr_valid) begin
      wr_en   = 1'b1;
      wr_addr = dfr_addr;
      wr_data = dfr_data;
    end else begin
      wr_en   = s1_adv && (s1.col != '0);
      wr_addr = s1.col - CW'(1);
      wr_data = pend_below + b3;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_level <= {sum_sat[GRAY_W-1:4], 4'b0000};
      out_end   <= s1.last_col && s1.last_row;
    end
  end

  assign results.valid     = out_valid;
  assign results.level_out = out_level;
  assign results.frame_end = out_end;

  // The deferred write never meets a write from the diffusion stage.
  `EDD_ASSERT_NOW(a_write_port_free, dfr_valid, !(s1_adv && (s1.col != '0)),
                  "line store write collision")
  // A finished last column always leaves its below share for the next cycle.
  `EDD_ASSERT_NEXT(a_last_col_write, s1_adv && s1.last_col, dfr_valid && (dfr_addr == $past(s1.col)),
                   "last column share not written")
  // The column counter stays inside the line store.
  `EDD_ASSERT_NOW(a_col_range, 1'b1, int'(col_count) < MAX_WIDTH,
                  "column counter out of range")
  // After the last column the next accepted pixel starts a row with no carry.
  `EDD_ASSERT_NEXT(a_row_start, s1_adv && s1.last_col, (right_carry == '0) && (pend_below == '0),
                   "row carries not cleared")

endmodule

FILE: design/edd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module edd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: bench/dither_level_checker.sv
// Checker that predicts the dithered level of every pixel request and compares results.
`timescale 1ns / 1ps

module dither_level_checker import edd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  edd_pixel_if  pixels,
  edd_result_if results,
  edd_cfg_if    cfg,
  output int    level_mismatches,
  output int    pending_levels
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [GRAY_W-1:0] level;
    logic              frame_end;
  } dither_out_t;

  // Shadow copy of the registers and of the diffusion state.
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [ERR_W-1:0]    row_below [DEF_MAX_WIDTH];
  logic [ERR_W-1:0]    carry_right;
  logic [ERR_W-1:0]    below_prev;
  int unsigned         col_pos;
  int unsigned         row_pos;

  dither_out_t expected_levels [$];
  int          fail_count = 0;

  // Quantizes one pixel and spreads its error to the right and to the next row.
  function automatic dither_out_t diffuse_pixel(input logic [GRAY_W-1:0] gray);
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned above;
    int unsigned sum;
    int unsigned err;
    int unsigned share3;
    int unsigned share5;
    logic        row_end;
    logic        last_of_frame;
    dither_out_t res;
    w_eff = (width_reg == 0) ? 1 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
    h_eff = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    row_end = (col_pos >= w_eff - 1);
    last_of_frame = row_end && (row_pos >= h_eff - 1);

    // The first row of a frame sees no error from above.
    above = (row_pos != 0) ? row_below[col_pos] : 0;
    sum = gray + carry_right + above;
    if (sum > 255) begin
      sum = 255;
    end
    err = sum % 16;
    share3 = (err * 3) / 16;
    share5 = (err * 5) / 16;

    // The previous column's entry is complete once this pixel adds its below-left share.
    if (col_pos >= 1) begin
      row_below[col_pos - 1] = ERR_W'(below_prev + share3);
    end
    if (row_end) begin
      row_below[col_pos] = ERR_W'(share5);
      carry_right = '0;
      below_prev = '0;
      col_pos = 0;
      row_pos = last_of_frame ? 0 : row_pos + 1;
    end else begin
      carry_right = ERR_W'((err * 7) / 16);
      below_prev = ERR_W'(share5);
      col_pos = col_pos + 1;
    end

    res.level = GRAY_W'(sum - err);
    res.frame_end = last_of_frame;
    return res;
  endfunction

  // Track register writes, predict on pixel requests, compare on results.
  always @(posedge clk) begin : watch
    dither_out_t seen;
    dither_out_t want;
    if (rst) begin
      width_reg = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      carry_right = '0;
      below_prev = '0;
      col_pos = 0;
      row_pos = 0;
      expected_levels.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          CFG_IMAGE_WIDTH: begin
            width_reg = cfg.data[WIDTH_W-1:0];
          end
          CFG_IMAGE_HEIGHT: begin
            height_reg = cfg.data[HEIGHT_W-1:0];
          end
          default: ;
        endcase
      end
      if (pixels.valid && pixels.ready) begin
        expected_levels.push_back(diffuse_pixel(pixels.gray_in));
      end
      if (results.valid && results.ready) begin
        seen.level = results.level_out;
        seen.frame_end = results.frame_end;
        if (expected_levels.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: unexpected result level_out=%0d frame_end=%0b", $time,
                     seen.level, seen.frame_end);
          end
        end else begin
          want = expected_levels.pop_front();
          if (seen.level !== want.level || seen.frame_end !== want.frame_end) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: level_out expected %0d got %0d, frame_end expected %0b got %0b",
                       $time, want.level, seen.level, want.frame_end, seen.frame_end);
            end
          end
        end
      end
    end
    level_mismatches <= fail_count;
    pending_levels <= expected_levels.size();
  end

endmodule

FILE: bench/error_diffusion_dither_test.sv
// Top of the dither testbench: clock, reset, pixel and register stimulus, and the verdict.
`timescale 1ns / 1ps

module error_diffusion_dither_test;
  import edd_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD    = 300;
  localparam int RUN_LIMIT_NS = 2000000;

  typedef enum logic [1:0] {PACE_STEADY, PACE_LIGHT, PACE_RANDOM} pace_t;
  typedef enum logic [1:0] {TONE_ANY, TONE_BRIGHT, TONE_DARK, TONE_FLAT} tone_t;

  logic  clk = 1'b0;
  logic  rst;
  pace_t src_pace = PACE_RANDOM;
  pace_t sink_pace;
  int    hold_asks = 0;
  int    holds_done = 0;
  int    level_mismatches;
  int    pending_levels;

  // Hand-picked pixels: saturation, zero and full-scale values, row edges.
  logic [GRAY_W-1:0] directed_grays [21] = '{
    250, 255, 255, 255,
    255, 7, 200, 16, 255,
    255, 15, 128,
    0, 255, 249, 15, 31, 255,
    128, 8, 100
  };

  edd_pixel_if  pixel_ch ();
  edd_result_if result_ch ();
  edd_cfg_if    cfg_ch ();

  error_diffusion_dither dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixel_ch),
    .results (result_ch),
    .cfg     (cfg_ch)
  );

  dither_level_checker levels_chk (
    .clk              (clk),
    .rst              (rst),
    .pixels           (pixel_ch),
    .results          (result_ch),
    .cfg              (cfg_ch),
    .level_mismatches (level_mismatches),
    .pending_levels   (pending_levels)
  );

  always #2 clk = ~clk;

  // Number of idle cycles before the next request on one side.
  function automatic int draw_gap(input pace_t pace);
    case (pace)
      PACE_STEADY: return 0;
      PACE_LIGHT:  return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      default:     return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [GRAY_W-1:0] pick_gray(input tone_t tone,
                                                  input logic [GRAY_W-1:0] flat);
    case (tone)
      TONE_BRIGHT: return GRAY_W'($urandom_range(232, 255));
      TONE_DARK:   return GRAY_W'($urandom_range(0, 20));
      TONE_FLAT:   return flat;
      default:     return GRAY_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Pixels in one frame once the register values are clamped.
  function automatic int frame_size(input int w, input int h);
    int wc;
    int hc;
    wc = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
    hc = (h == 0) ? 1 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
    return wc * hc;
  endfunction

  // Offers one pixel request and waits for it to be taken; valid stays high.
  task automatic send_one(input logic [GRAY_W-1:0] gray);
    int gap;
    gap = draw_gap(src_pace);
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.gray_in <= gray;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  task automatic send_grays(input int first, input int count);
    for (int i = first; i < first + count; i++) begin
      send_one(directed_grays[i]);
    end
    pixel_ch.valid <= 1'b0;
  endtask

  // Random pixels in short runs of one tone; pacing may change every 64 requests.
  task automatic send_burst(input int count, input bit repace);
    tone_t             tone;
    logic [GRAY_W-1:0] flat;
    for (int i = 0; i < count; i++) begin
      if (repace && i % 64 == 0) begin
        src_pace = pace_t'($urandom_range(0, 2));
        sink_pace <= pace_t'($urandom_range(0, 2));
      end
      if (i % 16 == 0) begin
        tone = tone_t'($urandom_range(0, 3));
        flat = GRAY_W'($urandom_range(0, 255));
      end
      send_one(pick_gray(tone, flat));
    end
    pixel_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted level has come back and the pipeline is empty.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_levels != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off when asked.
  initial begin : result_taker
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done++;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = draw_gap(sink_pace);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    int random_items;
    int phase;
    int w;
    int h;
    int frames;
    int n;
    rst <= 1'b1;
    pixel_ch.valid <= 1'b0;
    pixel_ch.gray_in <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_IMAGE_WIDTH;
    cfg_ch.data <= '0;
    sink_pace <= PACE_RANDOM;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes, then a mid-row shrink of the width that ends the row at once.
    send_grays(0, 4);
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 4);
    write_reg(CFG_IMAGE_HEIGHT, 2);
    send_grays(4, 5);

    // Zero width and height act as one: every pixel ends a frame.
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 0);
    write_reg(CFG_IMAGE_HEIGHT, 0);
    send_grays(9, 3);

    // Height with every bit set, then cut short mid-frame so the row count passes it.
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 3);
    write_reg(CFG_IMAGE_HEIGHT, 8191);
    send_grays(12, 6);
    wait_drained();
    write_reg(CFG_IMAGE_HEIGHT, 2);
    send_grays(18, 3);

    // Widest frame: a width with every bit set acts as the line store size.
    wait_drained();
    write_reg(CFG_IMAGE_WIDTH, 1023);
    write_reg(CFG_IMAGE_HEIGHT, 2);
    n = frame_size(1023, 2);
    send_burst(n, 1'b1);
    random_items = n;

    // Whole frames of random small sizes; the registers change only between frames.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      phase++;
      if (phase == 3) begin
        w = 20;
        h = 4;
        frames = 1;
      end else begin
        case ($urandom_range(0, 9))
          0:       w = 0;
          1:       w = 1;
          2:       w = $urandom_range(25, 64);
          default: w = $urandom_range(2, 24);
        endcase
        h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
        frames = $urandom_range(1, 2);
      end
      n = frames * frame_size(w, h);
      wait_drained();
      write_reg(CFG_IMAGE_WIDTH, w);
      write_reg(CFG_IMAGE_HEIGHT, h);
      if (phase == 3) begin
        // Results are held off while pixels keep coming, so the input backs up.
        src_pace = PACE_STEADY;
        hold_asks <= hold_asks + 1;
        send_burst(n, 1'b0);
      end else begin
        send_burst(n, 1'b1);
      end
      random_items += n;
    end

    wait_drained();
    if (level_mismatches == 0 && pending_levels == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/edd_pkg.sv
design/edd_ifs.sv
design/edd_ram.sv
design/error_diffusion_dither.sv
bench/dither_level_checker.sv
bench/error_diffusion_dither_test.sv
